FILE: src/hmac_sha1_engine_unit_defines.svh
`ifndef HMAC_SHA1_ENGINE_UNIT_DEFINES_SVH
`define HMAC_SHA1_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while reset is low.
`define HSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hse assertion failed");

// Next-cycle implication.
`define HSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hse assertion failed");

`endif

FILE: src/hse_pkg.sv
`timescale 1ns / 1ps
package hse_pkg;

    localparam int LENGTH_BITS_DEF = 61;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;
    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;
    localparam logic [7:0]  IPAD = 8'h36;
    localparam logic [7:0]  OPAD = 8'h5c;
    localparam logic [7:0]  PAD_START = 8'h80;
    localparam logic [63:0] OUTER_LEN_BITS = 64'd672;   // (64 + 20) bytes

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_KRAW, S_KHOLD, S_MHOLD,
        S_CKB, S_CKDIG, S_CKPS, S_CK36, S_CKEND,
        S_CMB, S_CMIN, S_CM5C, S_CMID, S_CMLEN,
        S_F80, S_FZ, S_FLEN,
        S_CLOAD, S_ROUND, S_CADD, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        SRC_HOLD, SRC_KEYRAW, SRC_K36, SRC_K5C, SRC_INNER, SRC_PAD, SRC_ZERO, SRC_LEN
    } t_src;

    typedef struct packed {
        logic       latch;
        logic       push;
        t_src       src;
        logic [5:0] idx;
        logic [6:0] rnd;
        logic       hash_start;
        logic       load_wv;
        logic       round;
        logic       add_chain;
        logic       key_write;
        logic       key_clear;
        logic       key_dig;
        logic       save_inner;
        logic       cnt_inc;
        logic       cnt_clr;
        logic       ovf_clr;
        logic       len_key;
        logic       len_inner;
        logic       len_outer;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic fill_56;
        logic cnt_lt64;
        logic cnt_eq64;
        logic cnt_gt64;
    } t_sts;

endpackage

FILE: src/hse_in_if.sv
`timescale 1ns / 1ps
interface hse_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, mode, has_byte, data_byte, last, input ready);
    modport sink (input valid, mode, has_byte, data_byte, last, output ready);
endinterface

FILE: src/hse_out_if.sv
`timescale 1ns / 1ps
interface hse_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
    logic        length_overflow;

    modport source (output valid, digest_word, word_index, final_word, length_overflow,
                    input ready);
    modport sink (input valid, digest_word, word_index, final_word, length_overflow,
                  output ready);
endinterface

FILE: src/hse_datapath.sv
`timescale 1ns / 1ps
module hse_datapath
    import hse_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_byte,
    output t_sts        o_sts,
    output logic [31:0] o_word,
    output logic        o_ovf
);

    logic [31:0] r_key [16];
    logic [31:0] r_w [16];
    logic [31:0] r_chain [5];
    logic [31:0] r_wv [5];
    logic [31:0] r_inner [5];
    logic [23:0] r_acc;
    logic [5:0]  r_fill;
    logic [LENGTH_BITS-1:0] r_cnt;
    logic        r_ovf;
    logic [63:0] r_len;
    logic [7:0]  r_hold;

    logic [31:0] key_w, inner_w, new_w, f, kc, sum, full_word;
    logic [7:0]  key_b, inner_b, pb;
    logic [4:0]  bsh;
    logic [LENGTH_BITS-1:0] cnt_max;
    logic [61:0] cnt_plus;

    assign cnt_max  = '1;
    assign bsh      = {~i_cmd.idx[1:0], 3'b000};
    assign key_w    = r_key[i_cmd.idx[5:2]];
    assign key_b    = 8'(key_w >> bsh);
    assign inner_w  = (i_cmd.idx[4:2] < 3'd5) ? r_inner[i_cmd.idx[4:2]] : '0;
    assign inner_b  = 8'(inner_w >> bsh);
    assign cnt_plus = 62'(r_cnt) + 62'd64;
    assign full_word = {r_acc, pb};
    assign new_w    = {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} << 1
                    | {31'd0, r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};

    always_comb begin
        unique case (i_cmd.src)
            SRC_HOLD:   pb = r_hold;
            SRC_KEYRAW: pb = key_b;
            SRC_K36:    pb = key_b ^ IPAD;
            SRC_K5C:    pb = key_b ^ OPAD;
            SRC_INNER:  pb = inner_b;
            SRC_PAD:    pb = PAD_START;
            SRC_ZERO:   pb = 8'd0;
            SRC_LEN:    pb = r_len[63:56];
            default:    pb = 8'd0;
        endcase
    end

    always_comb begin
        priority if (i_cmd.rnd < 7'd20) begin
            f  = (r_wv[1] & r_wv[2]) | (~r_wv[1] & r_wv[3]);
            kc = K0;
        end else if (i_cmd.rnd < 7'd40) begin
            f  = r_wv[1] ^ r_wv[2] ^ r_wv[3];
            kc = K1;
        end else if (i_cmd.rnd < 7'd60) begin
            f  = (r_wv[1] & r_wv[2]) | (r_wv[1] & r_wv[3]) | (r_wv[2] & r_wv[3]);
            kc = K2;
        end else begin
            f  = r_wv[1] ^ r_wv[2] ^ r_wv[3];
            kc = K3;
        end
        sum = {r_wv[0][26:0], r_wv[0][31:27]} + f + r_wv[4] + kc + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_chain <= '{H0, H1, H2, H3, H4};
            for (int i = 0; i < 16; i++) r_key[i] <= '0;
        end else begin
            if (i_cmd.latch) r_hold <= i_byte;
            if (i_cmd.hash_start) begin
                r_chain <= '{H0, H1, H2, H3, H4};
                r_fill  <= '0;
            end
            if (i_cmd.push) begin
                r_acc  <= full_word[23:0];
                r_fill <= r_fill + 6'd1;
                if (r_fill[1:0] == 2'd3) begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= full_word;
                end
                if (i_cmd.src == SRC_LEN) r_len <= {r_len[55:0], 8'd0};
            end
            if (i_cmd.load_wv) r_wv <= r_chain;
            if (i_cmd.round) begin
                r_wv[0] <= sum;
                r_wv[1] <= r_wv[0];
                r_wv[2] <= {r_wv[1][1:0], r_wv[1][31:2]};
                r_wv[3] <= r_wv[2];
                r_wv[4] <= r_wv[3];
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= new_w;
            end
            if (i_cmd.add_chain) begin
                for (int i = 0; i < 5; i++) r_chain[i] <= r_chain[i] + r_wv[i];
            end
            if (i_cmd.key_write) begin
                r_key[r_cnt[5:2]] <= (r_key[r_cnt[5:2]]
                                      & ~(32'hff << {~r_cnt[1:0], 3'b000}))
                                   | (32'(r_hold) << {~r_cnt[1:0], 3'b000});
            end
            if (i_cmd.key_clear) begin
                for (int i = 0; i < 16; i++) r_key[i] <= '0;
            end
            if (i_cmd.key_dig) begin
                for (int i = 0; i < 16; i++) r_key[i] <= (i < 5) ? r_chain[i % 5] : '0;
            end
            if (i_cmd.save_inner) r_inner <= r_chain;
            if (i_cmd.cnt_inc) begin
                if (r_cnt == cnt_max) r_ovf <= 1'b1;
                else r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.cnt_clr) r_cnt <= '0;
            if (i_cmd.ovf_clr) r_ovf <= 1'b0;
            if (i_cmd.len_key) r_len <= {64'(r_cnt)} << 3;
            if (i_cmd.len_inner) r_len <= {cnt_plus[60:0], 3'b000};
            if (i_cmd.len_outer) r_len <= OUTER_LEN_BITS;
        end
    end

    assign o_sts.fill_last = (r_fill == 6'd63);
    assign o_sts.fill_56   = (r_fill == 6'd56);
    assign o_sts.cnt_lt64  = (r_cnt < LENGTH_BITS'(64));
    assign o_sts.cnt_eq64  = (r_cnt == LENGTH_BITS'(64));
    assign o_sts.cnt_gt64  = (r_cnt > LENGTH_BITS'(64));
    assign o_word = (i_cmd.idx[2:0] < 3'd5) ? r_chain[i_cmd.idx[2:0]] : '0;
    assign o_ovf  = r_ovf;

endmodule

FILE: src/hse_ctrl.sv
`timescale 1ns / 1ps
`include "hmac_sha1_engine_unit_defines.svh"
module hse_ctrl
    import hse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_mode,
    input  logic       i_has,
    input  logic       i_last,
    input  logic       i_out_ready,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output logic [2:0] o_out_idx,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state, r_ret, n_ret, r_fret, n_fret, nxt;
    logic [5:0] r_idx, n_idx;
    logic [6:0] r_rnd, n_rnd;
    logic       r_phase, n_phase, r_mode, n_mode, r_has, n_has, r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_fret  <= S_IDLE;
            r_idx   <= '0;
            r_rnd   <= '0;
            r_phase <= 1'b0;
            r_mode  <= 1'b0;
            r_has   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fret  <= n_fret;
            r_idx   <= n_idx;
            r_rnd   <= n_rnd;
            r_phase <= n_phase;
            r_mode  <= n_mode;
            r_has   <= n_has;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_ret   = r_ret;
        n_fret  = r_fret;
        n_idx   = r_idx;
        n_rnd   = r_rnd;
        n_phase = r_phase;
        n_mode  = r_mode;
        n_has   = r_has;
        n_last  = r_last;
        nxt     = r_state;
        o_cmd   = '0;
        o_cmd.src = SRC_ZERO;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_mode = i_mode;
                    n_has  = i_has;
                    n_last = i_last;
                    nxt    = S_DISP;
                end
            end
            S_DISP: begin
                if (!r_phase && !r_mode) begin
                    if (r_has) begin
                        if (i_sts.cnt_lt64) begin
                            o_cmd.key_write = 1'b1;
                            o_cmd.cnt_inc   = 1'b1;
                            nxt = r_last ? S_CKB : S_IDLE;
                        end else if (i_sts.cnt_eq64) begin
                            // long key: start hashing the buffered 64 bytes
                            o_cmd.hash_start = 1'b1;
                            n_idx = '0;
                            nxt   = S_KRAW;
                        end else begin
                            nxt = S_KHOLD;
                        end
                    end else begin
                        nxt = r_last ? S_CKB : S_IDLE;
                    end
                end else if (!r_phase) begin
                    nxt = S_CKB;     // message beat closes the key first
                end else if (!r_mode) begin
                    nxt = S_IDLE;
                end else if (r_has) begin
                    nxt = S_MHOLD;
                end else begin
                    nxt = r_last ? S_CMB : S_IDLE;
                end
            end
            S_KRAW: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_KEYRAW;
                n_idx = r_idx + 6'd1;
                if (r_idx == 6'd63) nxt = S_KHOLD;
            end
            S_KHOLD: begin
                o_cmd.push    = 1'b1;
                o_cmd.src     = SRC_HOLD;
                o_cmd.cnt_inc = 1'b1;
                nxt = r_last ? S_CKB : S_IDLE;
            end
            S_MHOLD: begin
                o_cmd.push    = 1'b1;
                o_cmd.src     = SRC_HOLD;
                o_cmd.cnt_inc = 1'b1;
                nxt = r_last ? S_CMB : S_IDLE;
            end
            S_CKB: begin
                if (i_sts.cnt_gt64) begin
                    o_cmd.len_key = 1'b1;
                    n_fret = S_CKDIG;
                    nxt    = S_F80;
                end else begin
                    nxt = S_CKPS;
                end
            end
            S_CKDIG: begin
                o_cmd.key_dig = 1'b1;
                nxt = S_CKPS;
            end
            S_CKPS: begin
                o_cmd.hash_start = 1'b1;
                n_idx = '0;
                nxt   = S_CK36;
            end
            S_CK36: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_K36;
                n_idx = r_idx + 6'd1;
                if (r_idx == 6'd63) nxt = S_CKEND;
            end
            S_CKEND: begin
                o_cmd.cnt_clr = 1'b1;
                n_phase = 1'b1;
                nxt     = S_DISP;
            end
            S_CMB: begin
                o_cmd.len_inner = 1'b1;
                n_fret = S_CMIN;
                nxt    = S_F80;
            end
            S_CMIN: begin
                o_cmd.save_inner = 1'b1;
                o_cmd.hash_start = 1'b1;
                n_idx = '0;
                nxt   = S_CM5C;
            end
            S_CM5C: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_K5C;
                n_idx = r_idx + 6'd1;
                if (r_idx == 6'd63) begin
                    n_idx = '0;
                    nxt   = S_CMID;
                end
            end
            S_CMID: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_INNER;
                n_idx = r_idx + 6'd1;
                if (r_idx == 6'd19) nxt = S_CMLEN;
            end
            S_CMLEN: begin
                o_cmd.len_outer = 1'b1;
                n_fret = S_OUT;
                nxt    = S_F80;
            end
            S_F80: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_PAD;
                nxt = S_FZ;
            end
            S_FZ: begin
                if (i_sts.fill_56) begin
                    n_idx = '0;
                    nxt   = S_FLEN;
                end else begin
                    o_cmd.push = 1'b1;
                    o_cmd.src  = SRC_ZERO;
                end
            end
            S_FLEN: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_LEN;
                n_idx = r_idx + 6'd1;
                if (r_idx == 6'd7) begin
                    n_idx = '0;
                    nxt   = r_fret;
                end
            end
            S_CLOAD: begin
                o_cmd.load_wv = 1'b1;
                n_rnd = '0;
                nxt   = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == 7'd79) nxt = S_CADD;
            end
            S_CADD: begin
                o_cmd.add_chain = 1'b1;
                nxt = r_ret;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_idx == 6'd4) begin
                        o_cmd.key_clear  = 1'b1;
                        o_cmd.cnt_clr    = 1'b1;
                        o_cmd.ovf_clr    = 1'b1;
                        o_cmd.hash_start = 1'b1;
                        n_phase = 1'b0;
                        n_idx   = '0;
                        nxt     = S_IDLE;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            default: nxt = S_IDLE;
        endcase

        o_cmd.idx = r_idx;
        o_cmd.rnd = r_rnd;

        // a push that completes a block runs the compression before moving on
        if (o_cmd.push && i_sts.fill_last) begin
            n_ret   = nxt;
            n_state = S_CLOAD;
        end else begin
            n_state = nxt;
        end
    end

    assign o_out_idx = r_idx[2:0];

    `HSE_ASSERT_NOW(a_out_idx_range, i_clk, i_rst_n, o_out_valid, r_idx <= 6'd4)
    `HSE_ASSERT_NEXT(a_digest_done, i_clk, i_rst_n,
                     o_out_valid && i_out_ready && r_idx == 6'd4,
                     r_state == S_IDLE && !r_phase)
    `HSE_ASSERT_NEXT(a_round_end, i_clk, i_rst_n,
                     r_state == S_ROUND && r_rnd == 7'd79, r_state == S_CADD)
    `HSE_ASSERT_NOW(a_round_bound, i_clk, i_rst_n, r_state == S_ROUND, r_rnd <= 7'd79)

endmodule

FILE: src/hmac_sha1_engine_unit.sv
`timescale 1ns / 1ps
// HMAC-SHA1 engine, one byte per input beat.
// Input channel: beats with mode = 0 carry key bytes, then beats with mode = 1
// carry message bytes; a beat with last = 1 closes the key or the message, with
// or without a byte (has_byte). A message beat before the key is closed closes
// the key as it stands; key beats during a message are dropped.
// Output channel: on the beat that closes a message, five beats of 32-bit
// digest words follow, word_index 0..4, final_word on the last one, and
// length_overflow set if the byte counter saturated since the key began.
// Steps: a key byte of the first 64 is accepted, then written to the key store;
// a message byte or a long-key byte is accepted, dispatched, then pushed into
// the block; every 64th hashed byte runs the compression loop, one round per
// cycle. Closing a message runs inner padding, outer key block, inner digest
// and outer padding before the first digest word.
// Only one beat is in flight: the input is not ready while a beat is being
// worked on or while digest words wait; a stalled receiver holds the word.
// Reset (synchronous, active low) clears the key and counter and returns the
// engine to awaiting key bytes.
module hmac_sha1_engine_unit
    import hse_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hse_in_if.sink    i_in,
    hse_out_if.source o_out
);

    t_cmd       cmd;
    t_sts       sts;
    logic [2:0] out_idx;
    logic [31:0] word;
    logic       ovf;

    hse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_mode      (i_in.mode),
        .i_has       (i_in.has_byte),
        .i_last      (i_in.last),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_out_idx   (out_idx),
        .o_cmd       (cmd)
    );

    hse_datapath #(.LENGTH_BITS(LENGTH_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_byte  (i_in.data_byte),
        .o_sts   (sts),
        .o_word  (word),
        .o_ovf   (ovf)
    );

    assign o_out.digest_word     = word;
    assign o_out.word_index      = out_idx;
    assign o_out.final_word      = (out_idx == 3'd4);
    assign o_out.length_overflow = ovf;

endmodule
